@@ rtl/utc_to_local_date_weekday_unit_macros.svh @@
// Assertion macros used by the block's top-level RTL.
`ifndef UTC_TO_LOCAL_DATE_WEEKDAY_UNIT_MACROS_SVH
`define UTC_TO_LOCAL_DATE_WEEKDAY_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UTLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utld assertion failed");

// Next-cycle implication, checked outside reset.
`define UTLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utld assertion failed");

`endif

@@ rtl/utld_pkg.sv @@
`timescale 1ns / 1ps

package utld_pkg;

    // Day count origin: January 1st of this year is a Sunday.
    localparam int EPOCH_YEAR = 2017;
    localparam int EPOCH_P    = EPOCH_YEAR + 1999;
    // 365 is 1 mod 7, so the days before the origin year reduce to this sum.
    localparam logic [2:0] EPOCH_MOD7 =
        3'((EPOCH_P + EPOCH_P / 4 - EPOCH_P / 100 + EPOCH_P / 400) % 7);

    // Years are held biased by five whole 400-year cycles to stay positive.
    localparam logic [12:0] YEAR_BIAS = 13'd2000;

    // Reciprocal constants for division by 100 and by 7.
    localparam logic [15:0] RECIP_100       = 16'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [15:0] RECIP_7         = 16'd37450;
    localparam int          RECIP_7_SHIFT   = 18;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd60;

    // Command and status between controller and datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic mul_sum;
        logic div_en;
        logic check_en;
        logic sum_en;
        logic fin_en;
    } t_cmd;

    typedef struct packed {
        logic chk_valid;
        logic out_free;
    } t_sts;

    // Length of month m, zero for a month code out of range.
    function automatic logic [4:0] f_days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Days before the first of month m in a common year.
    function automatic logic [8:0] f_cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/utld_ctrl.sv @@
`timescale 1ns / 1ps

module utld_ctrl
    import utld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_YMUL1 = 9'b000000010,
        S_YDIV1 = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_YMUL2 = 9'b000010000,
        S_YDIV2 = 9'b000100000,
        S_SUM   = 9'b001000000,
        S_MMUL  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one item through the year divide and check, then for a valid item the day sum and mod-7 steps.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_YMUL1;
            end
            S_YMUL1: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_YDIV1;
            end
            S_YDIV1: begin
                o_cmd.div_en = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check_en = 1'b1;
                n_state = i_sts.chk_valid ? S_YMUL2 : S_FIN;
            end
            S_YMUL2: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_YDIV2;
            end
            S_YDIV2: begin
                o_cmd.div_en = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sum = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_en = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Hold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/utld_datapath.sv @@
`timescale 1ns / 1ps

module utld_datapath
    import utld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [39:0] i_in_data,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_out_data,
    output logic [1:0]  o_out_user
);

    logic [4:0]  r_tz;
    logic [12:0] r_yd;
    logic [3:0]  r_mon;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;
    logic        r_zerr;
    logic        r_valid;
    logic [28:0] r_prod;
    logic [5:0]  r_q100;
    logic        r_rz;
    logic        r_leap;
    logic [12:0] r_sum;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [1:0]  r_out_user;

    logic [12:0] mul_a;
    logic [15:0] mul_b;
    logic [5:0]  q100;
    logic [12:0] rem100;
    logic [4:0]  dim;
    logic        valid;
    logic [6:0]  hsum;
    logic        h_neg;
    logic        h_over;
    logic [3:0]  prev_mon;
    logic [8:0]  cum;
    logic        leap_adj;
    logic [13:0] s_pos;
    logic [13:0] s_neg;
    logic [10:0] q7;
    logic [2:0]  rem7;
    logic [2:0]  wd;
    logic        out_free;

    // Shared multiplier: year by 1/100, or day sum by 1/7.
    assign mul_a = i_cmd.mul_sum ? r_sum : r_yd;
    assign mul_b = i_cmd.mul_sum ? RECIP_7 : RECIP_100;

    // Year split into centuries and leap flag.
    assign q100   = 6'(r_prod >> RECIP_100_SHIFT);
    assign rem100 = r_yd - 13'(13'(q100) * 13'd100);

    // Range checks against the month length of the input year.
    assign dim   = f_days_in(r_mon, r_leap);
    assign valid = (r_mon >= MON_JAN) && (r_mon <= MON_DEC) && (r_day != 5'd0) &&
                   (r_day <= dim) && (r_hour <= HOUR_MAX) &&
                   (r_min <= MINSEC_MAX) && (r_sec <= MINSEC_MAX);

    // Offset hour, signed.
    assign hsum     = {2'b00, r_hour} + {{2{r_tz[4]}}, r_tz};
    assign h_neg    = hsum[6];
    assign h_over   = !hsum[6] && (hsum >= 7'd24);
    assign prev_mon = r_mon - 4'd1;

    // Day sum from the biased year; terms kept positive, offsets subtracted.
    assign cum      = f_cum_days(r_mon);
    assign leap_adj = r_leap && (r_mon > MON_FEB);
    assign s_pos = {1'b0, r_yd} + 14'(r_yd >> 2) + 14'(r_q100 >> 2) + 14'(cum) +
                   14'(r_day) + 14'(leap_adj) + 14'(r_rz);
    assign s_neg = 14'd2 + 14'(r_yd[1:0] == 2'b00) + 14'(r_q100) +
                   14'(r_rz && (r_q100[1:0] == 2'b00));

    // Weekday from the sum modulo 7, shifted to the origin.
    assign q7   = 11'(r_prod >> RECIP_7_SHIFT);
    assign rem7 = 3'(r_sum - 13'(13'(q7) * 13'd7));
    assign wd   = (rem7 >= EPOCH_MOD7) ? (rem7 - EPOCH_MOD7)
                                       : 3'(4'(rem7) + 4'd7 - 4'(EPOCH_MOD7));

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_sts.chk_valid = valid;
    assign o_sts.out_free  = out_free;

    // Hold the zone register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= 5'd0;
        end else if (i_cfg_wr_en) begin
            r_tz <= i_cfg_wr_data;
        end
    end

    // Work registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_yd   <= {1'b0, i_in_data[11:0]} + YEAR_BIAS;
            r_mon  <= i_in_data[15:12];
            r_day  <= i_in_data[20:16];
            r_hour <= i_in_data[25:21];
            r_min  <= i_in_data[31:26];
            r_sec  <= i_in_data[37:32];
            r_zerr <= ($signed(r_tz) < -5'sd12) || ($signed(r_tz) > 5'sd12);
        end
        if (i_cmd.mul_en) begin
            r_prod <= 29'(mul_a * mul_b);
        end
        if (i_cmd.div_en) begin
            r_q100 <= q100;
            r_rz   <= (rem100 == 13'd0);
            r_leap <= (r_yd[1:0] == 2'b00) && ((rem100 != 13'd0) || (q100[1:0] == 2'b00));
        end
        if (i_cmd.check_en) begin
            r_valid <= valid;
            // Apply the offset and roll the date by one day where needed.
            if (valid && !r_zerr) begin
                if (h_over) begin
                    r_hour <= 5'(hsum - 7'd24);
                    if (r_day == dim) begin
                        r_day <= 5'd1;
                        if (r_mon == MON_DEC) begin
                            r_mon <= MON_JAN;
                            r_yd  <= r_yd + 13'd1;
                        end else begin
                            r_mon <= r_mon + 4'd1;
                        end
                    end else begin
                        r_day <= r_day + 5'd1;
                    end
                end else if (h_neg) begin
                    r_hour <= 5'(hsum + 7'd24);
                    if (r_day == 5'd1) begin
                        if (r_mon == MON_JAN) begin
                            r_mon <= MON_DEC;
                            r_yd  <= r_yd - 13'd1;
                            r_day <= f_days_in(MON_DEC, 1'b0);
                        end else begin
                            r_mon <= prev_mon;
                            r_day <= f_days_in(prev_mon, r_leap);
                        end
                    end else begin
                        r_day <= r_day - 5'd1;
                    end
                end else begin
                    r_hour <= hsum[4:0];
                end
            end
        end
        if (i_cmd.sum_en) begin
            r_sum <= 13'(s_pos - s_neg);
        end
    end

    // Output register: load a finished item, drop it when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) begin
            r_out_data <= {7'd0, (r_valid ? wd : 3'd0), r_sec, r_min, r_hour, r_day,
                           r_mon, 12'(r_yd - YEAR_BIAS)};
            r_out_user <= {r_zerr, r_valid};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

@@ rtl/utc_to_local_date_weekday_unit.sv @@
`timescale 1ns / 1ps
// UTC to local date and weekday.
// Input stream (s_axis): one UTC date-time per item. The block checks it, adds the
// zone offset held in the configuration register, rolls the date by one day when
// the hour leaves 0..23, and gives the weekday of the local date (0 is Sunday).
// Output stream (m_axis): one result per input item, in order; tuser carries the
// date-valid and zone-error flags. Invalid items pass through with weekday 0.
// Configuration: i_cfg_wr_en writes the signed 5-bit offset in hours; write it
// only while no item is in flight. Offsets outside -12..12 raise zone_error and
// leave the date unadjusted.
// Sequence: after accepting an item the controller runs a multiply, a divide and the
// check, then for a valid item a second multiply and divide, the day sum and the
// mod-7 multiply before finishing; an invalid item goes straight to finish. The steps
// use the one shared multiplier (divide by 100, divide by 7); no new item is taken until idle.
// A finished item waits in the output register; if the receiver stalls, the
// block computes the next item and holds it until the register frees.
// Reset clears the offset to 0, empties the output and returns to idle.

module utc_to_local_date_weekday_unit
    import utld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // utc_year[11:0], utc_month[15:12], utc_day[20:16], utc_hour[25:21],
    // utc_minute[31:26], utc_second[37:32], zero[39:38]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // local_year[11:0], local_month[15:12], local_day[20:16], local_hour[25:21],
    // local_minute[31:26], local_second[37:32], weekday[40:38], zero[47:41]
    output logic [47:0] o_m_axis_tdata,
    // date_valid[0], zone_error[1]
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data
);

`include "utc_to_local_date_weekday_unit_macros.svh"

    t_cmd cmd;
    t_sts sts;

    utld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    utld_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_data     (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_out_user    (o_m_axis_tuser)
    );

    // Block goes busy right after it takes an item.
    `UTLD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // Rejected items carry weekday zero.
    `UTLD_ASSERT_NOW(a_invalid_wd_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[40:38] == 3'd0)
    // Accepted items leave with an hour and weekday in range.
    `UTLD_ASSERT_NOW(a_valid_ranges, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata[25:21] <= 5'd23) && (o_m_axis_tdata[40:38] <= 3'd6))

endmodule

@@ tb/local_date_checker.sv @@
`timescale 1ns / 1ps

module local_date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_utc_valid,
    input  logic        i_utc_ready,
    input  logic [39:0] i_utc_data,
    input  logic        i_local_valid,
    input  logic        i_local_ready,
    input  logic [47:0] i_local_data,
    input  logic [1:0]  i_local_flags,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    input  logic        i_flush,
    output int          o_pending,
    output int          o_mismatches
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        date_valid;
        logic        zone_error;
    } local_date_t;

    local_date_t        expected_dates[$];
    logic signed [4:0]  zone_hours;
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    function automatic bit leap_year(input int y);
        int r;
        r = ((y % 400) + 400) % 400;
        return (r == 0) || ((r % 4 == 0) && (r % 100 != 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        case (m)
            2:                        return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:              return 30;
            1, 3, 5, 7, 8, 10, 12:    return 31;
            default:                  return 0;
        endcase
    endfunction

    // Days before January 1st of year y, biased by whole 400-year cycles.
    function automatic int days_before_year(input int y);
        int p;
        p = y + 1999;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // Apply the zone offset to one UTC item and work out the local date and weekday.
    function automatic local_date_t local_date_of(input logic [39:0] word,
                                                  input logic signed [4:0] zone);
        int          y, mo, d, h, mi, s, tz, count, i;
        bit          ok, zerr;
        local_date_t r;
        y  = word[11:0];
        mo = word[15:12];
        d  = word[20:16];
        h  = word[25:21];
        mi = word[31:26];
        s  = word[37:32];
        tz = zone;
        zerr = (tz < -12) || (tz > 12);
        ok = (mo >= 1) && (mo <= 12) && (d >= 1) && (d <= month_days(y, mo)) &&
             (h <= 23) && (mi <= 60) && (s <= 60);
        r.weekday = '0;
        if (ok) begin
            if (!zerr) begin
                h += tz;
                if (h >= 24) begin
                    // advance one day, carry into month and year
                    h -= 24;
                    if (d == month_days(y, mo)) begin
                        d = 1;
                        if (mo == 12) begin
                            mo = 1;
                            y++;
                        end else begin
                            mo++;
                        end
                    end else begin
                        d++;
                    end
                end else if (h < 0) begin
                    // step back one day, borrow from month and year
                    h += 24;
                    if (d == 1) begin
                        if (mo == 1) begin
                            mo = 12;
                            y--;
                        end else begin
                            mo--;
                        end
                        d = month_days(y, mo);
                    end else begin
                        d--;
                    end
                end
            end
            count = days_before_year(y) - days_before_year(utld_pkg::EPOCH_YEAR);
            for (i = 1; i < mo; i++)
                count += month_days(y, i);
            count += d - 1;
            r.weekday = 3'(((count % 7) + 7) % 7);
        end
        r.year       = 12'(y);
        r.month      = 4'(mo);
        r.day        = 5'(d);
        r.hour       = 5'(h);
        r.minute     = 6'(mi);
        r.second     = 6'(s);
        r.date_valid = ok;
        r.zone_error = zerr;
        return r;
    endfunction

    // Compare the item on the output channel with the oldest prediction.
    task automatic compare_result(input local_date_t want);
        check_field("local_year",   i_local_data[11:0],  want.year);
        check_field("local_month",  i_local_data[15:12], want.month);
        check_field("local_day",    i_local_data[20:16], want.day);
        check_field("local_hour",   i_local_data[25:21], want.hour);
        check_field("local_minute", i_local_data[31:26], want.minute);
        check_field("local_second", i_local_data[37:32], want.second);
        check_field("weekday",      i_local_data[40:38], want.weekday);
        check_field("tdata padding", i_local_data[47:41], 0);
        check_field("date_valid",   i_local_flags[0],    want.date_valid);
        check_field("zone_error",   i_local_flags[1],    want.zone_error);
    endtask

    // Track the offset register, predict on input items, check output items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zone_hours <= '0;
            expected_dates.delete();
            o_pending <= 0;
        end else begin
            if (i_local_valid && i_local_ready) begin
                if (expected_dates.size() == 0)
                    report_mismatch("output item with no input item pending");
                else
                    compare_result(expected_dates.pop_front());
            end
            if (i_utc_valid && i_utc_ready)
                expected_dates.push_back(local_date_of(i_utc_data, zone_hours));
            if (i_cfg_wr_en)
                zone_hours <= i_cfg_wr_data;
            if (i_flush) begin
                while (expected_dates.size() != 0) begin
                    report_mismatch("predicted item never came out");
                    void'(expected_dates.pop_front());
                end
            end
            o_pending <= expected_dates.size();
        end
    end

endmodule

@@ tb/tb_utc_to_local_date_weekday_unit.sv @@
`timescale 1ns / 1ps

module tb_utc_to_local_date_weekday_unit;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 250;
    localparam int MODE_ITEMS    = 50;
    localparam int RANDOM_ZONE   = 99;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        utc_valid;
    logic        utc_ready;
    logic [39:0] utc_data;
    logic        local_valid;
    logic        local_ready;
    logic [47:0] local_data;
    logic [1:0]  local_flags;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        flush;
    int          pending;
    int          mismatches;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    utc_to_local_date_weekday_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (utc_valid),
        .o_s_axis_tready (utc_ready),
        .i_s_axis_tdata  (utc_data),
        .o_m_axis_tvalid (local_valid),
        .i_m_axis_tready (local_ready),
        .o_m_axis_tdata  (local_data),
        .o_m_axis_tuser  (local_flags),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    local_date_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_utc_valid   (utc_valid),
        .i_utc_ready   (utc_ready),
        .i_utc_data    (utc_data),
        .i_local_valid (local_valid),
        .i_local_ready (local_ready),
        .i_local_data  (local_data),
        .i_local_flags (local_flags),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_flush       (flush),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always #5 clk = ~clk;

    // Stall the output channel at the current rate.
    always @(posedge clk) begin
        if (!rst_n) begin
            local_ready <= 1'b0;
        end else begin
            local_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("utc_to_local_date_weekday_unit test failed");
            $finish;
        end
    end

    function automatic logic [39:0] pack_utc(input int y, input int mo, input int d,
                                             input int h, input int mi, input int s);
        return {2'b00, 6'(s), 6'(mi), 5'(h), 5'(d), 4'(mo), 12'(y)};
    endfunction

    // Mostly well-formed date-times near day and hour edges, the rest raw noise.
    function automatic logic [39:0] random_utc();
        int y, mo, d, h, mi, s, pick;
        pick = $urandom_range(99);
        if (pick < 85) begin
            y = $urandom_range(2105, 1970);
        end else if (pick < 95) begin
            y = $urandom_range(4095);
        end else begin
            case ($urandom_range(4))
                0:       y = 0;
                1:       y = 4095;
                2:       y = 2000;
                3:       y = 2100;
                default: y = 1999;
            endcase
        end
        if ($urandom_range(99) < 80) begin
            mo = $urandom_range(12, 1);
            pick = $urandom_range(99);
            if (pick < 25)
                d = 1;
            else if (pick < 60)
                d = $urandom_range(31, 28);
            else
                d = $urandom_range(31, 1);
            pick = $urandom_range(99);
            if (pick < 30)
                h = $urandom_range(3);
            else if (pick < 60)
                h = $urandom_range(23, 20);
            else
                h = $urandom_range(23);
            mi = ($urandom_range(19) == 0) ? 60 : $urandom_range(59);
            s  = ($urandom_range(19) == 0) ? 60 : $urandom_range(59);
        end else begin
            mo = $urandom_range(15);
            d  = $urandom_range(31);
            h  = $urandom_range(31);
            mi = $urandom_range(63);
            s  = $urandom_range(63);
        end
        return pack_utc(y, mo, d, h, mi, s);
    endfunction

    // Offer one item, idling first at the current rate, and hold it until taken.
    task automatic send_utc(input logic [39:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            utc_valid <= 1'b0;
            @(posedge clk);
        end
        utc_valid <= 1'b1;
        utc_data  <= word;
        @(posedge clk);
        while (!utc_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every predicted item to come out.
    task automatic drain_results();
        utc_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_zone(input int hours);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 5'(hours);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1: begin
                tx_idle_pct  = 68;
                rx_stall_pct = 0;
            end
            2: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 68;
            end
            default: begin
                tx_idle_pct  = 11;
                rx_stall_pct = 11;
            end
        endcase
    endtask

    int zone_plan[8] = '{0, 15, -16, 1, -1, 12, -12, RANDOM_ZONE};

    initial begin
        int p, n, zone;
        rst_n       <= 1'b0;
        utc_valid   <= 1'b0;
        utc_data    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        flush       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Forward rollover across day, month, year and the top of the year field.
        set_zone(12);
        send_utc(pack_utc(2105, 12, 31, 23, 59, 60));
        send_utc(pack_utc(4095, 12, 31, 12, 0, 0));
        send_utc(pack_utc(2000, 2, 28, 12, 0, 0));
        send_utc(pack_utc(2100, 2, 28, 12, 30, 30));
        send_utc(pack_utc(2016, 2, 29, 20, 60, 59));
        send_utc(pack_utc(2017, 4, 30, 11, 1, 1));
        send_utc(pack_utc(2017, 4, 30, 12, 2, 2));
        // Invalid items: out-of-range month, day, hour, minute and second.
        send_utc(pack_utc(2017, 0, 1, 0, 0, 0));
        send_utc(pack_utc(2017, 13, 1, 0, 0, 0));
        send_utc(pack_utc(4095, 15, 31, 31, 63, 63));
        send_utc(pack_utc(2017, 4, 31, 5, 0, 0));
        send_utc(pack_utc(2019, 2, 29, 5, 0, 0));
        send_utc(pack_utc(2017, 6, 10, 24, 0, 0));
        send_utc(pack_utc(2017, 6, 10, 5, 61, 0));
        send_utc(pack_utc(2017, 6, 10, 5, 0, 61));
        send_utc(pack_utc(2017, 6, 0, 5, 0, 0));

        // Backward rollover, including year zero wrapping below the field.
        set_zone(-12);
        send_utc(pack_utc(1970, 1, 1, 0, 0, 0));
        send_utc(pack_utc(0, 1, 1, 11, 0, 0));
        send_utc(pack_utc(2000, 3, 1, 5, 0, 0));
        send_utc(pack_utc(2100, 3, 1, 0, 0, 0));
        send_utc(pack_utc(2017, 1, 1, 12, 0, 0));

        // Offsets just outside and at the limits of the register.
        set_zone(13);
        send_utc(pack_utc(2017, 6, 15, 10, 30, 0));
        set_zone(-13);
        send_utc(pack_utc(2017, 12, 31, 23, 0, 0));
        set_zone(15);
        send_utc(pack_utc(2024, 2, 29, 1, 0, 0));
        set_zone(-16);
        send_utc(pack_utc(1970, 1, 1, 0, 0, 0));

        // Random phases, one offset each, idling pattern changing within a phase.
        for (p = 0; p < 8; p++) begin
            zone = (zone_plan[p] == RANDOM_ZONE) ? $urandom_range(31) : zone_plan[p];
            set_zone(zone);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % MODE_ITEMS == 0)
                    set_idling($urandom_range(3));
                send_utc(random_utc());
            end
        end

        drain_results();
        flush <= 1'b1;
        @(posedge clk);
        flush <= 1'b0;
        repeat (2) @(posedge clk);

        if (mismatches == 0)
            $display("utc_to_local_date_weekday_unit test passed");
        else
            $display("utc_to_local_date_weekday_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/utld_pkg.sv
rtl/utld_ctrl.sv
rtl/utld_datapath.sv
rtl/utc_to_local_date_weekday_unit.sv
tb/local_date_checker.sv
tb/tb_utc_to_local_date_weekday_unit.sv
